FILE: rtl/vector_magnitude_scale_regulator_top_defines.svh
// assertion macros for the vector magnitude scale regulator
`ifndef VECTOR_MAGNITUDE_SCALE_REGULATOR_TOP_DEFINES_SVH
`define VECTOR_MAGNITUDE_SCALE_REGULATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define VMSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vmsr check failed");
`define VMSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vmsr check failed");
`else
`define VMSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define VMSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/vmsr_pkg.sv
// shared types and constants for the vector magnitude scale regulator
package vmsr_pkg;

    localparam int GAIN_W = 32;
    localparam int BAND_W = 15;
    localparam int STEP_W = 31;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [BAND_W-1:0] BAND_RESET = 15'd41;
    localparam logic [STEP_W-1:0] STEP_RESET = 31'd1073849198;

    localparam logic REG_BAND = 1'b0;
    localparam logic REG_STEP = 1'b1;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_AMUL    = 10'b0000000010,
        S_AWAIT   = 10'b0000000100,
        S_SQ      = 10'b0000001000,
        S_SQWAIT  = 10'b0000010000,
        S_ROOT    = 10'b0000100000,
        S_RWAIT   = 10'b0001000000,
        S_UPD     = 10'b0010000000,
        S_UWAIT   = 10'b0100000000,
        S_DONE    = 10'b1000000000
    } t_state;

endpackage

FILE: rtl/vmsr_mul.sv
// shift-add multiplier, one multiplier bit per cycle
module vmsr_mul (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [vmsr_pkg::GAIN_W-1:0]     i_a,
    input  logic [vmsr_pkg::GAIN_W-1:0]     i_b,
    output logic                            o_busy,
    output logic [2*vmsr_pkg::GAIN_W-1:0]   o_prod
);
    import vmsr_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W + 1);

    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [2*GAIN_W-1:0] r_acc, n_acc, r_a, n_a;
    logic [GAIN_W-1:0]   r_b, n_b;

    always_comb begin
        n_cnt = r_cnt;
        n_acc = r_acc;
        n_a   = r_a;
        n_b   = r_b;
        if (i_start) begin
            n_cnt = CNT_W'(GAIN_W);
            n_acc = '0;
            n_a   = {{GAIN_W{1'b0}}, i_a};
            n_b   = i_b;
        end else if (r_cnt != '0) begin
            if (r_b[0]) begin
                n_acc = r_acc + r_a;
            end
            n_a   = r_a << 1;
            n_b   = r_b >> 1;
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
    end

    assign o_busy = (r_cnt != '0);
    assign o_prod = r_acc;

endmodule

FILE: rtl/vmsr_sqrt.sv
// floor square root, two radicand bits per cycle
module vmsr_sqrt #(
    parameter int W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2*W-1:0]   i_rad,
    output logic             o_busy,
    output logic [W-1:0]     o_root
);
    import vmsr_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [2*W-1:0]   r_rad, n_rad;
    logic [W:0]       r_rem, n_rem;
    logic [W-1:0]     r_root, n_root;
    logic [W+2:0]     rem_sh, trial;

    always_comb begin
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        rem_sh = {r_rem, r_rad[2*W-1:2*W-2]};
        trial  = {1'b0, r_root, 2'b01};
        if (i_start) begin
            n_cnt  = CNT_W'(W);
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
        end else if (r_cnt != '0) begin
            n_rad = r_rad << 2;
            if (rem_sh >= trial) begin
                n_rem  = W'(rem_sh - trial) == '0 ? (W+1)'(rem_sh - trial)
                                                  : (W+1)'(rem_sh - trial);
                n_root = {r_root[W-2:0], 1'b1};
            end else begin
                n_rem  = (W+1)'(rem_sh);
                n_root = {r_root[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_busy = (r_cnt != '0);
    assign o_root = r_root;

endmodule

FILE: rtl/vmsr_div.sv
// restoring divider, one quotient bit per cycle
module vmsr_div #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 31
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic               o_busy,
    output logic [NUM_W-1:0]   o_quo
);
    import vmsr_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_num, n_num, r_quo, n_quo;
    logic [DEN_W-1:0] r_den, n_den, r_rem, n_rem;
    logic [DEN_W:0]   rem_sh;

    always_comb begin
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_quo  = r_quo;
        n_den  = r_den;
        n_rem  = r_rem;
        rem_sh = {r_rem, r_num[NUM_W-1]};
        if (i_start) begin
            n_cnt = CNT_W'(NUM_W);
            n_num = i_num;
            n_den = i_den;
            n_rem = '0;
            n_quo = '0;
        end else if (r_cnt != '0) begin
            n_num = r_num << 1;
            if (rem_sh >= {1'b0, r_den}) begin
                n_rem = DEN_W'(rem_sh - {1'b0, r_den});
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = DEN_W'(rem_sh);
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_quo <= n_quo;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

FILE: rtl/vector_magnitude_scale_regulator_top.sv
// top level: axis scaling, magnitude and gain regulation sequencer
// a gain update follows when the magnitude error lies strictly inside the band: a multiply
// by the step factor when the magnitude is below unit, a divide by it, if nonzero, when above
// one request at a time; the input is ready only while the sequencer is idle
// a finished result waits in the output register while the next request is taken
// synchronous active-low reset restores gain 1.0 and the register defaults
`include "vector_magnitude_scale_regulator_top_defines.svh"
module vector_magnitude_scale_regulator_top #(
    parameter int SAMPLE_BITS    = 16,
    parameter int GAIN_FRAC_BITS = 30
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // axis_x, axis_y, axis_z, zero pad
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // scaled_x, scaled_y, scaled_z, zero pad
    output logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    o_m_axis_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [vmsr_pkg::APB_AW-1:0]           paddr,
    input  logic [vmsr_pkg::APB_DW-1:0]           pwdata,
    output logic [vmsr_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready
);
    import vmsr_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int GF    = GAIN_FRAC_BITS;
    localparam int DW    = ((3*SB+7)/8)*8;
    localparam int SUM_W = 2*SB;
    localparam int EW    = ((SB > BAND_W) ? SB : BAND_W) + 2;
    localparam int NUM_W = GAIN_W + GF;
    localparam logic [2*GAIN_W-1:0] POS_MAX = (64'd1 << (SB-1)) - 64'd1;
    localparam logic [EW-1:0]       UNIT    = EW'(1) << (SB-4);

    t_state              r_state, n_state;
    logic [1:0]          r_idx, n_idx;
    logic [SB-1:0]       r_axis [3];
    logic [SB-1:0]       r_scaled [3];
    logic [SB-1:0]       n_scaled;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [GAIN_W-1:0]   r_gain, n_gain;
    logic [BAND_W-1:0]   r_band;
    logic [STEP_W-1:0]   r_step;
    logic                r_isdiv, n_isdiv;
    logic                r_ovalid, n_ovalid;
    logic [3*SB-1:0]     r_out;

    logic                mul_start, mul_busy;
    logic [GAIN_W-1:0]   mul_a, mul_b;
    logic [2*GAIN_W-1:0] mul_prod;
    logic                sqrt_start, sqrt_busy;
    logic [SB-1:0]       sqrt_root;
    logic                div_start, div_busy;
    logic [NUM_W-1:0]    div_quo;

    logic [SB-1:0]       cur_axis, cur_mag, scl_mag;
    logic [2*GAIN_W-1:0] q, qn;
    logic                rem_nz;
    logic signed [EW-1:0] err, band_s;
    logic                cfg_wr, in_acc, out_load;

    vmsr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_prod  (mul_prod)
    );

    vmsr_sqrt #(.W(SB)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_sum),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    vmsr_div #(.NUM_W(NUM_W), .DEN_W(STEP_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_gain, {GF{1'b0}}}),
        .i_den   (r_step),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || i_m_axis_tready);

    assign cur_axis = r_axis[r_idx];
    assign cur_mag  = cur_axis[SB-1] ? SB'(-cur_axis) : cur_axis;
    assign scl_mag  = r_scaled[r_idx][SB-1] ? SB'(-r_scaled[r_idx]) : r_scaled[r_idx];

    assign mul_start  = (r_state == S_AMUL) || (r_state == S_SQ)
                        || ((r_state == S_UPD) && !r_isdiv);
    assign sqrt_start = (r_state == S_ROOT);
    assign div_start  = (r_state == S_UPD) && r_isdiv;

    always_comb begin
        mul_a = r_gain;
        mul_b = GAIN_W'(r_step);
        case (r_state)
            S_AMUL: begin
                mul_a = r_gain;
                mul_b = GAIN_W'(cur_mag);
            end
            S_SQ: begin
                mul_a = GAIN_W'(scl_mag);
                mul_b = GAIN_W'(scl_mag);
            end
            default: begin
                mul_a = r_gain;
                mul_b = GAIN_W'(r_step);
            end
        endcase
    end

    always_comb begin
        q      = mul_prod >> GF;
        rem_nz = |mul_prod[GF-1:0];
        qn     = q + {{(2*GAIN_W-1){1'b0}}, rem_nz};
        if (cur_axis[SB-1]) begin
            if (qn > POS_MAX + 64'd1) begin
                n_scaled = {1'b1, {(SB-1){1'b0}}};
            end else begin
                n_scaled = SB'(-qn);
            end
        end else begin
            if (q > POS_MAX) begin
                n_scaled = {1'b0, {(SB-1){1'b1}}};
            end else begin
                n_scaled = SB'(q);
            end
        end
    end

    assign err    = $signed(EW'(sqrt_root)) - $signed(UNIT);
    assign band_s = $signed(EW'(r_band));

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_gain   = r_gain;
        n_isdiv  = r_isdiv;
        n_ovalid = r_ovalid;
        if (i_m_axis_tready) begin
            n_ovalid = 1'b0;
        end
        if (out_load) begin
            n_ovalid = 1'b1;
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_idx   = '0;
                    n_sum   = '0;
                    n_state = S_AMUL;
                end
            end
            S_AMUL: begin
                n_state = S_AWAIT;
            end
            S_AWAIT: begin
                if (!mul_busy) begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_state = S_SQWAIT;
            end
            S_SQWAIT: begin
                if (!mul_busy) begin
                    n_sum = r_sum + mul_prod[SUM_W-1:0];
                    if (r_idx == 2'd2) begin
                        n_state = S_ROOT;
                    end else begin
                        n_idx   = r_idx + 2'd1;
                        n_state = S_AMUL;
                    end
                end
            end
            S_ROOT: begin
                n_state = S_RWAIT;
            end
            S_RWAIT: begin
                if (!sqrt_busy) begin
                    n_state = S_DONE;
                    if ((err > -band_s) && (err < band_s)) begin
                        if (err > 0 && r_step != '0) begin
                            n_isdiv = 1'b1;
                            n_state = S_UPD;
                        end else if (err < 0) begin
                            n_isdiv = 1'b0;
                            n_state = S_UPD;
                        end
                    end
                end
            end
            S_UPD: begin
                n_state = S_UWAIT;
            end
            S_UWAIT: begin
                if (r_isdiv && !div_busy) begin
                    n_gain  = (|div_quo[NUM_W-1:GAIN_W]) ? '1 : div_quo[GAIN_W-1:0];
                    n_state = S_DONE;
                end else if (!r_isdiv && !mul_busy) begin
                    n_gain  = (|mul_prod[2*GAIN_W-1:GF+GAIN_W]) ? '1
                              : mul_prod[GF+GAIN_W-1:GF];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_gain   <= GAIN_W'(1) << GF;
            r_band   <= BAND_RESET;
            r_step   <= STEP_RESET;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_gain   <= n_gain;
            if (cfg_wr && paddr[2] == REG_BAND) begin
                r_band <= pwdata[BAND_W-1:0];
            end
            if (cfg_wr && paddr[2] == REG_STEP) begin
                r_step <= pwdata[STEP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_sum   <= n_sum;
        r_isdiv <= n_isdiv;
        if (in_acc) begin
            r_axis[0] <= i_s_axis_tdata[SB-1:0];
            r_axis[1] <= i_s_axis_tdata[2*SB-1:SB];
            r_axis[2] <= i_s_axis_tdata[3*SB-1:2*SB];
        end
        if (r_state == S_AWAIT && !mul_busy) begin
            r_scaled[r_idx] <= n_scaled;
        end
        if (out_load) begin
            r_out <= {r_scaled[2], r_scaled[1], r_scaled[0]};
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = DW'(r_out);
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == REG_BAND) ? APB_DW'(r_band) : APB_DW'(r_step);

    `VMSR_ASSERT_IMP(a_idle_units, i_clk, i_rst_n, o_s_axis_tready, !mul_busy && !sqrt_busy && !div_busy)
    `VMSR_ASSERT_IMP(a_one_unit, i_clk, i_rst_n, 1'b1, $onehot0({mul_busy, sqrt_busy, div_busy}))
    `VMSR_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_acc, !o_s_axis_tready)

endmodule

FILE: verif/vector_magnitude_scale_regulator_top_tb.sv
// testbench for the vector magnitude scale regulator: random and directed requests, scoreboard check
`timescale 1ns / 1ps

class vmsr_gain_scoreboard;
    logic [14:0] band;
    logic [30:0] step;
    logic [31:0] gain;
    logic [47:0] expected_q[$];
    int          errors;

    function new();
        band   = vmsr_pkg::BAND_RESET;
        step   = vmsr_pkg::STEP_RESET;
        gain   = 32'h4000_0000;
        errors = 0;
    endfunction

    function automatic logic [15:0] scale_axis(logic [15:0] a, logic [31:0] g);
        longint          av;
        logic     [63:0] mag;
        logic     [63:0] prod;
        logic     [63:0] q;
        av   = longint'($signed(a));
        mag  = (av < 0) ? 64'(-av) : 64'(av);
        prod = mag * 64'(g);
        q    = prod >> 30;
        if (av < 0) begin
            if (prod[29:0] != 0) q = q + 1;
            if (q > 64'd32768) return 16'h8000;
            return 16'(-q);
        end
        if (q > 64'd32767) return 16'h7fff;
        return q[15:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function void note_request(logic [47:0] d);
        logic [15:0] s[3];
        logic [63:0] sum;
        logic [63:0] t;
        longint      sv;
        longint      err;
        longint      b;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            s[i] = scale_axis(d[16*i +: 16], gain);
            sv   = longint'($signed(s[i]));
            sum  = sum + 64'(sv * sv);
        end
        expected_q.push_back({s[2], s[1], s[0]});
        err = longint'(floor_sqrt(sum)) - 4096;
        b   = longint'(band);
        if (-b < err && err < b) begin
            if (err > 0 && step != 0) begin
                t    = (64'(gain) << 30) / 64'(step);
                gain = (t > 64'hffff_ffff) ? 32'hffff_ffff : t[31:0];
            end else if (err < 0) begin
                t    = (64'(gain) * 64'(step)) >> 30;
                gain = (t > 64'hffff_ffff) ? 32'hffff_ffff : t[31:0];
            end
        end
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task check_result(logic [47:0] d);
        logic [47:0] e;
        if (expected_q.size() == 0) begin
            report("unexpected result", d[15:0], 16'h0);
            return;
        end
        e = expected_q.pop_front();
        if (d[15:0] != e[15:0]) report("scaled_x", d[15:0], e[15:0]);
        if (d[31:16] != e[31:16]) report("scaled_y", d[31:16], e[31:16]);
        if (d[47:32] != e[47:32]) report("scaled_z", d[47:32], e[47:32]);
    endtask
endclass

module vector_magnitude_scale_regulator_top_tb;
    import vmsr_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [47:0]       m_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    vmsr_gain_scoreboard sb;
    int                  burst_left = 0;
    int                  idle_cycles = 0;
    int                  cycle_no = 0;
    int                  stall_mode = 0;

    always #2 i_clk = ~i_clk;

    vector_magnitude_scale_regulator_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready), .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready), .o_m_axis_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // receiver, checker and watchdog
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no % 97 == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
        if ((i_rst_n && m_tvalid && m_tready) || (s_tvalid && s_tready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 20000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_request(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        s_tdata  <= {z, y, x};
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_request({z, y, x});
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid   <= 1'b0;
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 400)) @(posedge i_clk);
            else repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BAND) sb.band = value[14:0];
        else sb.step = value[30:0];
        @(posedge i_clk);
    endtask

    task automatic set_regs(logic [31:0] band, logic [31:0] step);
        drain();
        apb_write(REG_BAND, band);
        apb_write(REG_STEP, step);
    endtask

    // mostly vectors near unit length so the gain keeps adapting
    task automatic random_requests(int n);
        logic [15:0] v[3];
        int          k;
        int          r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 9);
            k = $urandom_range(0, 2);
            for (int j = 0; j < 3; j++) v[j] = 16'($urandom_range(0, 65535));
            if (r < 5) begin
                for (int j = 0; j < 3; j++) v[j] = 16'(int'($urandom_range(0, 400)) - 200);
                v[k] = 16'(4096 + int'($urandom_range(0, 160)) - 80);
                if ($urandom_range(0, 1)) v[k] = -v[k];
            end else if (r < 7) begin
                v[k]         = 16'(2896 + int'($urandom_range(0, 60)) - 30);
                v[(k+1) % 3] = 16'(2896 + int'($urandom_range(0, 60)) - 30);
                v[(k+2) % 3] = 16'(int'($urandom_range(0, 40)) - 20);
            end else if (r < 8) begin
                for (int j = 0; j < 3; j++) v[j] = 16'(int'($urandom_range(0, 8000)) - 4000);
            end
            send_request(v[0], v[1], v[2]);
        end
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes and unit-length vectors at reset settings
        send_request(16'h7fff, 16'h7fff, 16'h7fff);
        send_request(16'h8000, 16'h8000, 16'h8000);
        send_request(16'h0000, 16'h0000, 16'h0000);
        send_request(16'hffff, 16'h0001, 16'h8000);
        send_request(16'd4096, 16'h0000, 16'h0000);
        send_request(16'd4100, 16'h0000, 16'h0000);
        send_request(16'd4090, 16'h0000, 16'h0000);
        send_request(16'h0000, -16'd4096, 16'h0000);
        send_request(16'h0000, 16'h0000, -16'd4110);
        send_request(16'h0000, 16'h0000, -16'd4080);
        send_request(16'haaaa, 16'h5555, 16'haaaa);
        send_request(16'h5555, 16'haaaa, 16'h5555);
        random_requests(250);

        set_regs(32'd32767, 32'h7fff_ffff);
        send_request(16'd4095, 16'd0, 16'd0);
        send_request(16'd4097, 16'd0, 16'd0);
        random_requests(250);

        // zero band never adapts
        set_regs(32'd0, 32'h4000_0000);
        random_requests(200);

        // zero step factor is ignored on the divide, when the magnitude is above unit
        set_regs(32'd32767, 32'd0);
        send_request(16'd4200, 16'd0, 16'd0);
        random_requests(200);

        // tiny step factor drives the gain to saturation
        set_regs(32'd200, 32'd1);
        send_request(16'd4150, 16'd0, 16'd0);
        random_requests(200);

        set_regs(32'd32767, 32'h7fff_ffff);
        random_requests(200);

        set_regs(32'd41, 32'd1073849198);
        random_requests(250);

        // gain collapses to zero and stays there
        set_regs(32'd32767, 32'd1);
        send_request(16'd100, 16'd0, 16'd0);
        send_request(16'd100, 16'd0, 16'd0);
        random_requests(300);

        drain();
        repeat (320) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
